// File: src/sci_pkg.sv
// ----------------------------------------------------------------------------
// sci_pkg: shared types and constants of the static contact impulse unit
// fixed point helpers, status codes, register map and queue entry type
// ----------------------------------------------------------------------------
package sci_pkg;

	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int QW = 32;
	localparam int DIV_NUM_W = 58;
	localparam int DIV_DEN_W = 31;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [30:0] IMPULSE_LIMIT_RESET = 31'd65536000;
	localparam logic [15:0] SEP_THRESHOLD_RESET = 16'd7;
	localparam logic [15:0] MIN_DENOM_RESET = 16'd1;

	typedef enum logic [1:0] {
		ST_APPLIED    = 2'd0,
		ST_SEPARATING = 2'd1,
		ST_DEGENERATE = 2'd2,
		ST_CLAMPED    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_IMPULSE_LIMIT = 2'd0,
		REG_SEP_THRESH    = 2'd1,
		REG_MIN_DENOM     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [30:0] impulse_limit;
		logic [15:0] separation_threshold;
		logic [15:0] min_denominator;
	} cfg_t;

	// classified contact handed from the front to the back
	typedef struct packed {
		logic                 active;
		status_t              status;
		logic signed [31:0]   nx;
		logic signed [31:0]   ny;
		logic [DIV_NUM_W-1:0] num_mag;
		logic                 num_neg;
		logic [30:0]          denom;
	} entry_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647)
			return 32'sh7fffffff;
		else if (x < -66'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	// saturate a full product after a floor shift (arithmetic shift = floor)
	function automatic logic signed [31:0] qfix(input logic signed [63:0] p,
		input int frac);
		logic signed [65:0] s;
		s = 66'(p) >>> frac;
		return sat32(s);
	endfunction

endpackage

// File: src/sci_front.sv
// ----------------------------------------------------------------------------
// sci_front: contact classification pipeline
// computes contact velocity, approach speed and denominator, decides status
// ----------------------------------------------------------------------------
module sci_front #(
	parameter int FRAC_BITS = sci_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  nx,
	input  logic signed [31:0]  ny,
	input  logic signed [31:0]  rx,
	input  logic signed [31:0]  ry,
	input  logic signed [31:0]  vx,
	input  logic signed [31:0]  vy,
	input  logic signed [31:0]  w,
	input  logic [30:0]         inv_i,
	input  logic [30:0]         inv_m,
	input  logic [16:0]         ba,
	input  logic [16:0]         bb,
	input  sci_pkg::cfg_t       cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output sci_pkg::entry_t     out_entry
);
	import sci_pkg::*;

	// wide enough for one at the largest fraction width plus a restitution
	localparam int QOW = 26;
	localparam logic [QOW-1:0] Q_ONE = QOW'(1) << FRAC_BITS;

	logic adv;
	logic v1_q, v2_q, v3_q, v4_q;
	assign adv = out_ready || !v4_q;
	assign in_ready = adv;

	// stage 1: spin products and lever cross terms
	logic signed [31:0] nx_s1, ny_s1, vx_s1, vy_s1, wry_s1, wrx_s1, rxny_s1, rynx_s1;
	logic [30:0] inv_i_s1, inv_m_s1;
	logic [16:0] bn_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s1 <= nx;
			ny_s1 <= ny;
			vx_s1 <= vx;
			vy_s1 <= vy;
			wry_s1 <= qfix(64'(w) * 64'(ry), FRAC_BITS);
			wrx_s1 <= qfix(64'(w) * 64'(rx), FRAC_BITS);
			rxny_s1 <= qfix(64'(rx) * 64'(ny), FRAC_BITS);
			rynx_s1 <= qfix(64'(ry) * 64'(nx), FRAC_BITS);
			inv_i_s1 <= inv_i;
			inv_m_s1 <= inv_m;
			bn_s1 <= (ba < bb) ? ba : bb;
		end
	end

	// stage 2: relative velocity, lever cross
	logic signed [31:0] relx_c, rely_c, cx_c;
	assign cx_c = sat32(-66'(wry_s1));
	assign relx_c = sat32(-66'(sat32(66'(vx_s1) + 66'(cx_c))));
	assign rely_c = sat32(-66'(sat32(66'(vy_s1) + 66'(wrx_s1))));
	logic signed [31:0] nx_s2, ny_s2, relx_s2, rely_s2, rn_s2;
	logic [30:0] inv_i_s2, inv_m_s2;
	logic [17:0] bn_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s2 <= nx_s1;
			ny_s2 <= ny_s1;
			relx_s2 <= relx_c;
			rely_s2 <= rely_c;
			rn_s2 <= sat32(66'(rxny_s1) - 66'(rynx_s1));
			inv_i_s2 <= inv_i_s1;
			inv_m_s2 <= inv_m_s1;
			bn_s2 <= (QOW'(bn_s1) > Q_ONE) ? 18'(Q_ONE) : 18'(bn_s1);
		end
	end

	// stage 3: approach speed products and rn squared
	logic signed [31:0] nx_s3, ny_s3, pa_s3, pb_s3, rn2_s3;
	logic [30:0] inv_i_s3, inv_m_s3;
	logic [17:0] bn_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
			pa_s3 <= qfix(64'(relx_s2) * 64'(nx_s2), FRAC_BITS);
			pb_s3 <= qfix(64'(rely_s2) * 64'(ny_s2), FRAC_BITS);
			rn2_s3 <= qfix(64'(rn_s2) * 64'(rn_s2), FRAC_BITS);
			inv_i_s3 <= inv_i_s2;
			inv_m_s3 <= inv_m_s2;
			bn_s3 <= bn_s2;
		end
	end

	// stage 4: van, denominator, restitution numerator, classification
	logic signed [31:0] van_c, rni_c, denom_c;
	logic [QOW-1:0] q1_c;
	logic signed [63:0] num_c;
	assign van_c = sat32(66'(pa_s3) + 66'(pb_s3));
	assign rni_c = qfix(64'(rn2_s3) * 64'($signed({1'b0, inv_i_s3})), FRAC_BITS);
	assign denom_c = sat32(66'($signed({1'b0, inv_m_s3})) + 66'(rni_c));
	assign q1_c = Q_ONE + QOW'(bn_s3);
	assign num_c = -(64'($signed({1'b0, q1_c})) * 64'(van_c));
	entry_t e_c;
	always_comb begin
		e_c.active = 1'b0;
		e_c.status = ST_APPLIED;
		e_c.nx = nx_s3;
		e_c.ny = ny_s3;
		e_c.num_neg = num_c[63];
		e_c.num_mag = DIV_NUM_W'(num_c[63] ? -num_c : num_c);
		e_c.denom = denom_c[30:0];
		if (van_c >= $signed({16'd0, cfg.separation_threshold}))
			e_c.status = ST_SEPARATING;
		else if (denom_c <= 0 || denom_c < $signed({16'd0, cfg.min_denominator}))
			e_c.status = ST_DEGENERATE;
		else
			e_c.active = 1'b1;
	end
	always_ff @(posedge clk) begin
		if (adv) out_entry <= e_c;
	end

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else if (adv) begin
			v1_q <= in_valid;
			v2_q <= v1_q;
			v3_q <= v2_q;
			v4_q <= v3_q;
		end
	end
	assign out_valid = v4_q;

endmodule

// File: src/sci_queue.sv
// ----------------------------------------------------------------------------
// sci_queue: short queue between classification and impulse stages
// register array with read and write pointers
// ----------------------------------------------------------------------------
module sci_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sci_pkg::entry_t in_entry,
	output logic            out_valid,
	input  logic            out_ready,
	output sci_pkg::entry_t out_entry
);
	import sci_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	entry_t mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != (AW+1)'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_entry = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_entry;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// File: src/sci_back.sv
// ----------------------------------------------------------------------------
// sci_back: impulse execution pipeline
// pipelined restoring divide, clamp and projection onto the normal
// ----------------------------------------------------------------------------
module sci_back #(
	parameter int FRAC_BITS = sci_pkg::FRAC_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sci_pkg::entry_t    in_entry,
	input  logic [30:0]        impulse_limit,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] impulse_x,
	output logic signed [31:0] impulse_y,
	output logic [1:0]         status
);
	import sci_pkg::*;

	localparam int BPS = 2;
	localparam int NST = (DIV_NUM_W + BPS - 1) / BPS;
	localparam int RW = DIV_DEN_W + 1;

	logic adv;
	logic [NST+2:0] v_q;
	assign adv = out_ready || !v_q[NST+2];
	assign in_ready = adv;

	// divider stages, two quotient bits each
	entry_t ent_q [NST+1];
	logic [DIV_NUM_W-1:0] quo_q [NST+1];
	logic [RW-1:0] rem_q [NST+1];
	always_ff @(posedge clk) begin
		if (adv) begin
			ent_q[0] <= in_entry;
			quo_q[0] <= in_entry.num_mag;
			rem_q[0] <= '0;
		end
	end
	for (genvar s = 0; s < NST; s++) begin : g_div
		logic [DIV_NUM_W-1:0] qn;
		logic [RW-1:0] rn;
		always_comb begin
			logic [RW:0] t;
			qn = quo_q[s];
			rn = rem_q[s];
			for (int b = 0; b < BPS; b++) begin
				t = {rn, qn[DIV_NUM_W-1]};
				qn = {qn[DIV_NUM_W-2:0], 1'b0};
				if (t >= {2'b0, ent_q[s].denom}) begin
					t = t - {2'b0, ent_q[s].denom};
					qn[0] = 1'b1;
				end
				rn = t[RW-1:0];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ent_q[s+1] <= ent_q[s];
				quo_q[s+1] <= qn;
				rem_q[s+1] <= rn;
			end
		end
	end

	// clamp
	logic [DIV_NUM_W-1:0] qm;
	logic clamp_c;
	entry_t ex_c;
	assign qm = quo_q[NST];
	assign clamp_c = qm > DIV_NUM_W'(impulse_limit);
	always_comb begin
		ex_c = ent_q[NST];
		if (ent_q[NST].active)
			ex_c.status = clamp_c ? ST_CLAMPED : ST_APPLIED;
	end
	logic signed [31:0] j_s1;
	entry_t e_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1 <= ex_c;
			if (clamp_c)
				j_s1 <= ent_q[NST].num_neg ? -$signed({1'b0, impulse_limit})
					: $signed({1'b0, impulse_limit});
			else
				j_s1 <= ent_q[NST].num_neg ? -$signed(qm[31:0]) : $signed(qm[31:0]);
		end
	end

	// projection onto the normal
	always_ff @(posedge clk) begin
		if (adv) begin
			status <= e_s1.status;
			impulse_x <= e_s1.active ? qfix(64'(e_s1.nx) * 64'(j_s1), FRAC_BITS) : '0;
			impulse_y <= e_s1.active ? qfix(64'(e_s1.ny) * 64'(j_s1), FRAC_BITS) : '0;
		end
	end

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NST+1:0], in_valid};
	end
	assign out_valid = v_q[NST+2];

endmodule

// File: src/static_contact_impulse_unit.sv
// ----------------------------------------------------------------------------
// static_contact_impulse_unit: normal contact impulse against a static body
// Takes one contact per cycle unless stalled; returns one result per contact.
// A four-stage front classifies each contact (separating, degenerate or
// active), a four-entry queue decouples it from the back, which runs a
// pipelined two-bit-per-stage divider (29 stages) plus clamp and projection.
// Every stage is fully pipelined, so throughput is one item per cycle while no
// result is held; a result passes through the four front stages, the queue,
// the input register, 29 divider stages, clamp and projection. A held result
// stalls the back, and the front keeps going until the queue fills.
// ----------------------------------------------------------------------------
module static_contact_impulse_unit #(
	parameter int FRAC_BITS = sci_pkg::FRAC_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] normal_x,
	input  logic signed [31:0] normal_y,
	input  logic signed [31:0] arm_x,
	input  logic signed [31:0] arm_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] spin_rate,
	input  logic [30:0]        inverse_inertia,
	input  logic [30:0]        inverse_mass,
	input  logic [16:0]        bounce_a,
	input  logic [16:0]        bounce_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] impulse_x,
	output logic signed [31:0] impulse_y,
	output logic [1:0]         status
);
	import sci_pkg::*;

	cfg_t cfg_q;
	logic [1:0] ridx;
	assign pready = 1'b1;
	assign ridx = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.impulse_limit <= IMPULSE_LIMIT_RESET;
			cfg_q.separation_threshold <= SEP_THRESHOLD_RESET;
			cfg_q.min_denominator <= MIN_DENOM_RESET;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_IMPULSE_LIMIT: cfg_q.impulse_limit <= pwdata[30:0];
				REG_SEP_THRESH:    cfg_q.separation_threshold <= pwdata[15:0];
				REG_MIN_DENOM:     cfg_q.min_denominator <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (ridx)
			REG_IMPULSE_LIMIT: prdata = {1'b0, cfg_q.impulse_limit};
			REG_SEP_THRESH:    prdata = {16'd0, cfg_q.separation_threshold};
			REG_MIN_DENOM:     prdata = {16'd0, cfg_q.min_denominator};
			default:           prdata = '0;
		endcase
	end

	logic f_valid, f_ready, b_valid, b_ready;
	entry_t f_entry, b_entry;

	sci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.nx(normal_x), .ny(normal_y), .rx(arm_x), .ry(arm_y),
		.vx(vel_x), .vy(vel_y), .w(spin_rate),
		.inv_i(inverse_inertia), .inv_m(inverse_mass), .ba(bounce_a), .bb(bounce_b),
		.cfg(cfg_q), .out_valid(f_valid), .out_ready(f_ready), .out_entry(f_entry)
	);

	sci_queue u_queue (
		.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready), .in_entry(f_entry),
		.out_valid(b_valid), .out_ready(b_ready), .out_entry(b_entry)
	);

	sci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .in_valid(b_valid), .in_ready(b_ready), .in_entry(b_entry),
		.impulse_limit(cfg_q.impulse_limit), .out_valid, .out_ready,
		.impulse_x, .impulse_y, .status
	);

endmodule
